// ===== src/bas_pkg.sv =====
// Shared constants, payload types and small helpers for the ballistic arc solver.
// Depends on nothing; every other file in src uses it by scoped names.
package bas_pkg;

  // Fixed-point and datapath constants.
  localparam int GUARD         = 8;
  localparam int CORDIC_STEPS  = 20;
  localparam int CORDIC_LAT    = CORDIC_STEPS + 3;
  localparam int ISQRT_IN_W    = 112;
  localparam int ISQRT_OUT_W   = ISQRT_IN_W / 2;
  localparam int ISQRT_LAT     = ISQRT_OUT_W;
  localparam int NORM_MSB      = 39;
  localparam int VEC_W         = 58;
  localparam int ROT_W         = 44;
  localparam int U_W           = 40;

  localparam logic [23:0] GRAVITY_RESET = 24'd642253;
  localparam logic [29:0] INV_GAIN      = 30'd652032874;

  // Solution count codes.
  localparam logic [1:0] SOL_NONE = 2'd0;
  localparam logic [1:0] SOL_ONE  = 2'd1;
  localparam logic [1:0] SOL_TWO  = 2'd2;

  // Input beat.
  typedef struct packed {
    logic signed [31:0] launch_x;
    logic signed [31:0] launch_y;
    logic signed [31:0] launch_z;
    logic signed [31:0] aim_x;
    logic signed [31:0] aim_y;
    logic signed [31:0] aim_z;
    logic        [25:0] launch_speed;
  } cmd_t;

  // Result beat.
  typedef struct packed {
    logic        [1:0]  solution_count;
    logic               degenerate;
    logic signed [27:0] low_vx;
    logic signed [27:0] low_vy;
    logic signed [27:0] low_vz;
    logic signed [27:0] high_vx;
    logic signed [27:0] high_vy;
    logic signed [27:0] high_vz;
  } res_t;

  // Drop the guard bits, rounding half up, and keep 28 bits.
  function automatic logic [27:0] round_out(input logic [U_W-1:0] v);
    logic [U_W:0] t;
    t = {v[U_W-1], v} + (U_W+1)'(1 << (GUARD - 1));
    return t[GUARD+27:GUARD];
  endfunction

endpackage

// ===== src/bas_isqrt.sv =====
// Pipelined floor square root, one result bit per register stage.
// Depends on bas_pkg for the operand width and the stage count.
module bas_isqrt (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [bas_pkg::ISQRT_IN_W-1:0]   n_i,
  output logic                             valid_o,
  output logic [bas_pkg::ISQRT_OUT_W-1:0]  root_o
);

  localparam int NW = bas_pkg::ISQRT_IN_W;
  localparam int RW = bas_pkg::ISQRT_OUT_W;

  logic [NW-1:0] st_rem_q [0:RW-1];
  logic [RW-1:0] st_root_q [0:RW-1];
  logic          st_valid_q [0:RW-1];

  // Each stage tries one root bit, from the top down, on the running remainder.
  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [NW-1:0] rem_prev;
    logic [RW-1:0] root_prev;
    logic          valid_prev;
    logic [NW:0]   trial;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_prev   = n_i;
      assign root_prev  = '0;
      assign valid_prev = valid_i;
    end else begin : g_next
      assign rem_prev   = st_rem_q[k-1];
      assign root_prev  = st_root_q[k-1];
      assign valid_prev = st_valid_q[k-1];
    end

    always_comb begin
      trial = ((NW+1)'(root_prev) << (B + 1)) | ((NW+1)'(1) << (2 * B));
      take  = {1'b0, rem_prev} >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_valid_q[k] <= 1'b0;
      end else begin
        st_valid_q[k] <= valid_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      if (take) begin
        st_rem_q[k]  <= rem_prev - trial[NW-1:0];
        st_root_q[k] <= root_prev | (RW'(1) << B);
      end else begin
        st_rem_q[k]  <= rem_prev;
        st_root_q[k] <= root_prev;
      end
    end
  end

  assign valid_o = st_valid_q[RW-1];
  assign root_o  = st_root_q[RW-1];

endmodule

// ===== src/bas_cordic.sv =====
// Pipelined CORDIC: vectors on (p, q) and applies the same rotation to (u, 0).
// Three setup stages (magnitude, leading one and gain product, normalize) then one stage per step.
// Depends on bas_pkg for widths, step count and the gain constant.
module bas_cordic (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic signed [bas_pkg::VEC_W-1:0] p_i,
  input  logic signed [bas_pkg::VEC_W-1:0] q_i,
  input  logic signed [bas_pkg::U_W-1:0]   u_i,
  output logic                             valid_o,
  output logic signed [bas_pkg::U_W-1:0]   u_o,
  output logic signed [bas_pkg::U_W-1:0]   w_o
);

  localparam int VW = bas_pkg::VEC_W;
  localparam int RW = bas_pkg::ROT_W;
  localparam int UW = bas_pkg::U_W;
  localparam int NS = bas_pkg::CORDIC_STEPS;

  // Stage one: magnitudes and the larger of the two.
  logic [VW-1:0] mp_w, mq_w;
  logic          c1_valid_q, c1_pneg_q, c1_qneg_q;
  logic [VW-1:0] c1_mp_q, c1_mq_q, c1_m_q;
  logic [UW-1:0] c1_u_q;

  always_comb begin
    mp_w = p_i[VW-1] ? VW'(-p_i) : VW'(p_i);
    mq_w = q_i[VW-1] ? VW'(-q_i) : VW'(q_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_valid_q <= 1'b0;
    end else begin
      c1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_mp_q   <= mp_w;
    c1_mq_q   <= mq_w;
    c1_m_q    <= (mp_w > mq_w) ? mp_w : mq_w;
    c1_pneg_q <= p_i[VW-1];
    c1_qneg_q <= q_i[VW-1];
    c1_u_q    <= u_i;
  end

  // Stage two: leading one position and the gain compensation products.
  logic [5:0]    pos_w;
  logic [UW-1:0] um_w;
  logic          c2_valid_q, c2_zero_q, c2_pneg_q, c2_qneg_q;
  logic [5:0]    c2_pos_q;
  logic [VW-1:0] c2_mp_q, c2_mq_q;
  logic [UW-1:0] c2_u_q;
  logic [39:0]   c2_ghi_q;
  logic [59:0]   c2_glo_q;

  always_comb begin
    pos_w = '0;
    for (int k = 0; k < VW; k++) begin
      if (c1_m_q[k]) begin
        pos_w = 6'(k);
      end
    end
    um_w = c1_u_q[UW-1] ? UW'(-c1_u_q) : c1_u_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c2_valid_q <= 1'b0;
    end else begin
      c2_valid_q <= c1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c2_pos_q  <= pos_w;
    c2_zero_q <= (c1_m_q == '0);
    c2_mp_q   <= c1_mp_q;
    c2_mq_q   <= c1_mq_q;
    c2_pneg_q <= c1_pneg_q;
    c2_qneg_q <= c1_qneg_q;
    c2_u_q    <= c1_u_q;
    c2_ghi_q  <= 40'(um_w[UW-1:30]) * 40'(bas_pkg::INV_GAIN);
    c2_glo_q  <= 60'(um_w[29:0]) * 60'(bas_pkg::INV_GAIN);
  end

  // Stage three: normalize both coordinates and finish the gain product.
  logic [40:0]    sp_w, sq_w;
  logic [5:0]     rs_w, ls_w;
  logic [UW:0]    ug_w;
  logic [UW-1:0]  u0_w;

  logic signed [RW-1:0] st_p_q [0:NS];
  logic signed [RW-1:0] st_q_q [0:NS];
  logic signed [UW-1:0] st_u_q [0:NS];
  logic signed [UW-1:0] st_w_q [0:NS];
  logic                 st_zero_q [0:NS];
  logic                 st_valid_q [0:NS];

  always_comb begin
    rs_w = c2_pos_q - 6'(bas_pkg::NORM_MSB);
    ls_w = 6'(bas_pkg::NORM_MSB) - c2_pos_q;
    if (c2_pos_q > 6'(bas_pkg::NORM_MSB)) begin
      sp_w = 41'(c2_mp_q >> rs_w);
      sq_w = 41'(c2_mq_q >> rs_w);
    end else begin
      sp_w = 41'(c2_mp_q << ls_w);
      sq_w = 41'(c2_mq_q << ls_w);
    end
    ug_w = (UW+1)'(c2_ghi_q) + (UW+1)'(c2_glo_q >> 30);
    if (c2_zero_q) begin
      u0_w = c2_u_q;
    end else if (c2_u_q[UW-1]) begin
      u0_w = UW'(-ug_w);
    end else begin
      u0_w = UW'(ug_w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q[0] <= 1'b0;
    end else begin
      st_valid_q[0] <= c2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st_p_q[0]    <= c2_pneg_q ? RW'(-$signed({1'b0, sp_w})) : RW'($signed({1'b0, sp_w}));
    st_q_q[0]    <= c2_qneg_q ? RW'(-$signed({1'b0, sq_w})) : RW'($signed({1'b0, sq_w}));
    st_u_q[0]    <= $signed(u0_w);
    st_w_q[0]    <= '0;
    st_zero_q[0] <= c2_zero_q;
  end

  // Rotation steps; a zero vector passes through untouched.
  for (genvar i = 0; i < NS; i++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_valid_q[i+1] <= 1'b0;
      end else begin
        st_valid_q[i+1] <= st_valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      st_zero_q[i+1] <= st_zero_q[i];
      if (st_zero_q[i]) begin
        st_p_q[i+1] <= st_p_q[i];
        st_q_q[i+1] <= st_q_q[i];
        st_u_q[i+1] <= st_u_q[i];
        st_w_q[i+1] <= st_w_q[i];
      end else if (!st_q_q[i][RW-1]) begin
        st_p_q[i+1] <= st_p_q[i] + (st_q_q[i] >>> i);
        st_q_q[i+1] <= st_q_q[i] - (st_p_q[i] >>> i);
        st_u_q[i+1] <= st_u_q[i] - (st_w_q[i] >>> i);
        st_w_q[i+1] <= st_w_q[i] + (st_u_q[i] >>> i);
      end else begin
        st_p_q[i+1] <= st_p_q[i] - (st_q_q[i] >>> i);
        st_q_q[i+1] <= st_q_q[i] + (st_p_q[i] >>> i);
        st_u_q[i+1] <= st_u_q[i] + (st_w_q[i] >>> i);
        st_w_q[i+1] <= st_w_q[i] - (st_u_q[i] >>> i);
      end
    end
  end

  assign valid_o = st_valid_q[NS];
  assign u_o     = st_u_q[NS];
  assign w_o     = st_w_q[NS];

endmodule

// ===== src/ballistic_arc_solver.sv =====
// Top level of the ballistic arc solver: front arithmetic, root and CORDIC stages.
// Depends on bas_pkg, bas_isqrt and bas_cordic.
//
//  channel   | ports                               | handshake
//  ----------+-------------------------------------+------------------------------
//  command   | start, busy, cmd_i                  | beat taken when start && !busy
//  result    | res_valid_o, res_o                  | one-cycle strobe, no backpressure
//  gravity   | cfg_valid_i, cfg_ready_o, cfg_data_i| beat taken when valid && ready
//
// One command beat per cycle. Each beat passes seven front stages, the 56 one-bit
// root stages, one stage after them, two 23-stage CORDIC units in series and one
// output stage.
// busy never rises and the pipeline never stalls, since results cannot be held off.
// Reset clears the valid bits and sets gravity to 9.8; no clearing pass is needed.
module ballistic_arc_solver (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  bas_pkg::cmd_t  cmd_i,
  output logic           res_valid_o,
  output bas_pkg::res_t  res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [23:0]    cfg_data_i
);

  localparam int UW = bas_pkg::U_W;
  localparam int VW = bas_pkg::VEC_W;

  // Gravity register.
  logic [23:0] grav_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= bas_pkg::GRAVITY_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      grav_q <= cfg_data_i;
    end
  end

  // Stage 1: coordinate differences.
  logic               s1_valid_q;
  logic signed [32:0] s1_dx_q, s1_dy_q, s1_dz_q;
  logic        [25:0] s1_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_dx_q <= $signed({cmd_i.aim_x[31], cmd_i.aim_x})
             - $signed({cmd_i.launch_x[31], cmd_i.launch_x});
    s1_dy_q <= $signed({cmd_i.aim_y[31], cmd_i.aim_y})
             - $signed({cmd_i.launch_y[31], cmd_i.launch_y});
    s1_dz_q <= $signed({cmd_i.aim_z[31], cmd_i.aim_z})
             - $signed({cmd_i.launch_z[31], cmd_i.launch_z});
    s1_v_q  <= cmd_i.launch_speed;
  end

  // Stage 2: magnitudes, squares and the first gravity products.
  logic [32:0] mdx_w, mdy_w, mdz_w;
  logic        s2_valid_q, s2_dyneg_q, s2_degen_q;
  logic [65:0] s2_sqx_q, s2_sqz_q;
  logic [51:0] s2_v2_q;
  logic [47:0] s2_g2_q;
  logic [56:0] s2_gdy_q;
  logic [32:0] s2_dx_q, s2_dz_q;
  logic [25:0] s2_v_q;

  always_comb begin
    mdx_w = s1_dx_q[32] ? 33'(-s1_dx_q) : 33'(s1_dx_q);
    mdy_w = s1_dy_q[32] ? 33'(-s1_dy_q) : 33'(s1_dy_q);
    mdz_w = s1_dz_q[32] ? 33'(-s1_dz_q) : 33'(s1_dz_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_sqx_q   <= 66'(mdx_w) * 66'(mdx_w);
    s2_sqz_q   <= 66'(mdz_w) * 66'(mdz_w);
    s2_v2_q    <= 52'(s1_v_q) * 52'(s1_v_q);
    s2_g2_q    <= 48'(grav_q) * 48'(grav_q);
    s2_gdy_q   <= 57'(grav_q) * 57'(mdy_w);
    s2_dyneg_q <= s1_dy_q[32];
    s2_degen_q <= (s1_dx_q == '0) && (s1_dz_q == '0);
    s2_dx_q    <= s1_dx_q;
    s2_dz_q    <= s1_dz_q;
    s2_v_q     <= s1_v_q;
  end

  // Stage 3: horizontal distance squared and partial products of v^4 and g*|dy|*v^2.
  logic        s3_valid_q, s3_dyneg_q, s3_degen_q;
  logic [65:0] s3_x2_q;
  logic [51:0] s3_vhh_q, s3_vhl_q, s3_vll_q;
  logic [54:0] s3_ghh_q, s3_ghl_q;
  logic [53:0] s3_glh_q, s3_gll_q;
  logic [47:0] s3_g2_q;
  logic [51:0] s3_v2_q;
  logic [32:0] s3_dx_q, s3_dz_q;
  logic [25:0] s3_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_x2_q    <= s2_sqx_q + s2_sqz_q;
    s3_vhh_q   <= 52'(s2_v2_q[51:26]) * 52'(s2_v2_q[51:26]);
    s3_vhl_q   <= 52'(s2_v2_q[51:26]) * 52'(s2_v2_q[25:0]);
    s3_vll_q   <= 52'(s2_v2_q[25:0]) * 52'(s2_v2_q[25:0]);
    s3_ghh_q   <= 55'(s2_gdy_q[56:28]) * 55'(s2_v2_q[51:26]);
    s3_ghl_q   <= 55'(s2_gdy_q[56:28]) * 55'(s2_v2_q[25:0]);
    s3_glh_q   <= 54'(s2_gdy_q[27:0]) * 54'(s2_v2_q[51:26]);
    s3_gll_q   <= 54'(s2_gdy_q[27:0]) * 54'(s2_v2_q[25:0]);
    s3_g2_q    <= s2_g2_q;
    s3_v2_q    <= s2_v2_q;
    s3_dyneg_q <= s2_dyneg_q;
    s3_degen_q <= s2_degen_q;
    s3_dx_q    <= s2_dx_q;
    s3_dz_q    <= s2_dz_q;
    s3_v_q     <= s2_v_q;
  end

  // Stage 4: sum v^4 and g*|dy|*v^2; partial products of x^2 * g^2.
  logic         s4_valid_q, s4_dyneg_q, s4_degen_q;
  logic [103:0] s4_v4_q;
  logic [108:0] s4_gv_q;
  logic [45:0]  s4_p0l_q, s4_p1l_q, s4_p2l_q, s4_p0h_q, s4_p1h_q, s4_p2h_q;
  logic [65:0]  s4_x2_q;
  logic [51:0]  s4_v2_q;
  logic [32:0]  s4_dx_q, s4_dz_q;
  logic [25:0]  s4_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_v4_q    <= (104'(s3_vhh_q) << 52) + (104'(s3_vhl_q) << 27) + 104'(s3_vll_q);
    s4_gv_q    <= (109'(s3_ghh_q) << 54) + (109'(s3_ghl_q) << 28)
                + (109'(s3_glh_q) << 26) + 109'(s3_gll_q);
    s4_p0l_q   <= 46'(s3_x2_q[21:0])  * 46'(s3_g2_q[23:0]);
    s4_p1l_q   <= 46'(s3_x2_q[43:22]) * 46'(s3_g2_q[23:0]);
    s4_p2l_q   <= 46'(s3_x2_q[65:44]) * 46'(s3_g2_q[23:0]);
    s4_p0h_q   <= 46'(s3_x2_q[21:0])  * 46'(s3_g2_q[47:24]);
    s4_p1h_q   <= 46'(s3_x2_q[43:22]) * 46'(s3_g2_q[47:24]);
    s4_p2h_q   <= 46'(s3_x2_q[65:44]) * 46'(s3_g2_q[47:24]);
    s4_x2_q    <= s3_x2_q;
    s4_v2_q    <= s3_v2_q;
    s4_dyneg_q <= s3_dyneg_q;
    s4_degen_q <= s3_degen_q;
    s4_dx_q    <= s3_dx_q;
    s4_dz_q    <= s3_dz_q;
    s4_v_q     <= s3_v_q;
  end

  // Stage 5: v^4 -+ 2*g*y*v^2, and the two halves of x^2 * g^2.
  logic         s5_valid_q, s5_degen_q;
  logic [111:0] s5_d1_q;
  logic [89:0]  s5_al_q, s5_ah_q;
  logic [65:0]  s5_x2_q;
  logic [51:0]  s5_v2_q;
  logic [32:0]  s5_dx_q, s5_dz_q;
  logic [25:0]  s5_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_dyneg_q) begin
      s5_d1_q <= 112'(s4_v4_q) + (112'(s4_gv_q) << 1);
    end else begin
      s5_d1_q <= 112'(s4_v4_q) - (112'(s4_gv_q) << 1);
    end
    s5_al_q    <= 90'(s4_p0l_q) + (90'(s4_p1l_q) << 22) + (90'(s4_p2l_q) << 44);
    s5_ah_q    <= 90'(s4_p0h_q) + (90'(s4_p1h_q) << 22) + (90'(s4_p2h_q) << 44);
    s5_x2_q    <= s4_x2_q;
    s5_v2_q    <= s4_v2_q;
    s5_degen_q <= s4_degen_q;
    s5_dx_q    <= s4_dx_q;
    s5_dz_q    <= s4_dz_q;
    s5_v_q     <= s4_v_q;
  end

  // Stage 6: full x^2 * g^2.
  logic         s6_valid_q, s6_degen_q;
  logic [111:0] s6_d1_q;
  logic [113:0] s6_xg_q;
  logic [65:0]  s6_x2_q;
  logic [51:0]  s6_v2_q;
  logic [32:0]  s6_dx_q, s6_dz_q;
  logic [25:0]  s6_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else begin
      s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_xg_q    <= 114'(s5_al_q) + (114'(s5_ah_q) << 24);
    s6_d1_q    <= s5_d1_q;
    s6_x2_q    <= s5_x2_q;
    s6_v2_q    <= s5_v2_q;
    s6_degen_q <= s5_degen_q;
    s6_dx_q    <= s5_dx_q;
    s6_dz_q    <= s5_dz_q;
    s6_v_q     <= s5_v_q;
  end

  // Stage 7: discriminant and its sign.
  logic [115:0] disc_w;
  logic         s7_valid_q, s7_degen_q, s7_neg_q;
  logic [111:0] s7_d_q;
  logic [65:0]  s7_x2_q;
  logic [51:0]  s7_v2_q;
  logic [32:0]  s7_dx_q, s7_dz_q;
  logic [25:0]  s7_v_q;

  assign disc_w = {{4{s6_d1_q[111]}}, s6_d1_q} - {2'b00, s6_xg_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_valid_q <= 1'b0;
    end else begin
      s7_valid_q <= s6_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_d_q     <= disc_w[111:0];
    s7_neg_q   <= disc_w[115];
    s7_x2_q    <= s6_x2_q;
    s7_v2_q    <= s6_v2_q;
    s7_degen_q <= s6_degen_q;
    s7_dx_q    <= s6_dx_q;
    s7_dz_q    <= s6_dz_q;
    s7_v_q     <= s6_v_q;
  end

  // Square roots of x^2 and of the discriminant, side by side.
  logic                            rx_valid_w, rd_valid_w;
  logic [bas_pkg::ISQRT_OUT_W-1:0] rx_w, rd_w;

  bas_isqrt u_isqrt_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s7_valid_q),
    .n_i     (bas_pkg::ISQRT_IN_W'(s7_x2_q)),
    .valid_o (rx_valid_w),
    .root_o  (rx_w)
  );

  bas_isqrt u_isqrt_d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s7_valid_q),
    .n_i     (s7_d_q),
    .valid_o (rd_valid_w),
    .root_o  (rd_w)
  );

  // Item data that rides along the root stages.
  typedef struct packed {
    logic [51:0] v2;
    logic [25:0] v;
    logic [32:0] dx;
    logic [32:0] dz;
    logic        degen;
    logic        neg;
  } root_side_t;

  root_side_t root_line_q [0:bas_pkg::ISQRT_LAT-1];
  root_side_t root_out_w;

  always_ff @(posedge clk_i) begin
    root_line_q[0] <= '{v2: s7_v2_q, v: s7_v_q, dx: s7_dx_q, dz: s7_dz_q,
                        degen: s7_degen_q, neg: s7_neg_q};
    for (int k = 1; k < bas_pkg::ISQRT_LAT; k++) begin
      root_line_q[k] <= root_line_q[k-1];
    end
  end

  assign root_out_w = root_line_q[bas_pkg::ISQRT_LAT-1];

  // Arc arguments: b = g*x and a = v^2 -+ root.
  logic        t1_valid_q, t1_degen_q, t1_neg_q, t1_rootz_q;
  logic [56:0] t1_b_q;
  logic [57:0] t1_alow_q, t1_ahigh_q;
  logic [25:0] t1_v_q;
  logic [32:0] t1_dx_q, t1_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_valid_q <= 1'b0;
    end else begin
      t1_valid_q <= rx_valid_w;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_b_q     <= 57'(grav_q) * 57'(rx_w[32:0]);
    t1_alow_q  <= 58'(root_out_w.v2) - 58'(rd_w);
    t1_ahigh_q <= 58'(root_out_w.v2) + 58'(rd_w);
    t1_rootz_q <= (rd_w == '0);
    t1_v_q     <= root_out_w.v;
    t1_dx_q    <= root_out_w.dx;
    t1_dz_q    <= root_out_w.dz;
    t1_degen_q <= root_out_w.degen;
    t1_neg_q   <= root_out_w.neg;
  end

  // Elevation CORDIC: horizontal speed and vertical velocity for both arcs.
  logic                 c1l_valid_w, c1h_valid_w;
  logic signed [UW-1:0] hl_w, vyl_w, hh_w, vyh_w;
  logic signed [UW-1:0] speed_w;

  assign speed_w = $signed({6'b0, t1_v_q, 8'b0});

  bas_cordic u_elev_low (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (t1_valid_q),
    .p_i     ($signed({1'b0, t1_b_q})),
    .q_i     ($signed(t1_alow_q)),
    .u_i     (speed_w),
    .valid_o (c1l_valid_w),
    .u_o     (hl_w),
    .w_o     (vyl_w)
  );

  bas_cordic u_elev_high (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (t1_valid_q),
    .p_i     ($signed({1'b0, t1_b_q})),
    .q_i     ($signed(t1_ahigh_q)),
    .u_i     (speed_w),
    .valid_o (c1h_valid_w),
    .u_o     (hh_w),
    .w_o     (vyh_w)
  );

  typedef struct packed {
    logic [32:0] dx;
    logic [32:0] dz;
    logic        degen;
    logic        neg;
    logic        rootz;
  } elev_side_t;

  elev_side_t elev_line_q [0:bas_pkg::CORDIC_LAT-1];
  elev_side_t elev_out_w;

  always_ff @(posedge clk_i) begin
    elev_line_q[0] <= '{dx: t1_dx_q, dz: t1_dz_q, degen: t1_degen_q, neg: t1_neg_q,
                        rootz: t1_rootz_q};
    for (int k = 1; k < bas_pkg::CORDIC_LAT; k++) begin
      elev_line_q[k] <= elev_line_q[k-1];
    end
  end

  assign elev_out_w = elev_line_q[bas_pkg::CORDIC_LAT-1];

  // Ground direction, folded into the right half plane when dx is negative.
  logic                 flip_w;
  logic signed [VW-1:0] gdx_w, gdz_w;

  always_comb begin
    flip_w = elev_out_w.dx[32];
    gdx_w  = $signed({{(VW-33){elev_out_w.dx[32]}}, elev_out_w.dx});
    gdz_w  = $signed({{(VW-33){elev_out_w.dz[32]}}, elev_out_w.dz});
    if (flip_w) begin
      gdx_w = -gdx_w;
      gdz_w = -gdz_w;
    end
  end

  // Azimuth CORDIC: split the horizontal speed into x and z.
  logic                 c2l_valid_w, c2h_valid_w;
  logic signed [UW-1:0] vxl_w, vzl_w, vxh_w, vzh_w;

  bas_cordic u_azim_low (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c1l_valid_w),
    .p_i     (gdx_w),
    .q_i     (gdz_w),
    .u_i     (hl_w),
    .valid_o (c2l_valid_w),
    .u_o     (vxl_w),
    .w_o     (vzl_w)
  );

  bas_cordic u_azim_high (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c1h_valid_w),
    .p_i     (gdx_w),
    .q_i     (gdz_w),
    .u_i     (hh_w),
    .valid_o (c2h_valid_w),
    .u_o     (vxh_w),
    .w_o     (vzh_w)
  );

  typedef struct packed {
    logic [UW-1:0] vy_low;
    logic [UW-1:0] vy_high;
    logic          flip;
    logic          degen;
    logic          neg;
    logic          rootz;
  } azim_side_t;

  azim_side_t azim_line_q [0:bas_pkg::CORDIC_LAT-1];
  azim_side_t azim_out_w;

  always_ff @(posedge clk_i) begin
    azim_line_q[0] <= '{vy_low: vyl_w, vy_high: vyh_w, flip: flip_w,
                        degen: elev_out_w.degen, neg: elev_out_w.neg,
                        rootz: elev_out_w.rootz};
    for (int k = 1; k < bas_pkg::CORDIC_LAT; k++) begin
      azim_line_q[k] <= azim_line_q[k-1];
    end
  end

  assign azim_out_w = azim_line_q[bas_pkg::CORDIC_LAT-1];

  // Output stage: undo the fold, round, and pick the fields by case.
  logic [UW-1:0] fxl_w, fzl_w, fxh_w, fzh_w;
  bas_pkg::res_t res_d, res_q;
  logic          res_valid_q;

  always_comb begin
    fxl_w = azim_out_w.flip ? UW'(-vxl_w) : UW'(vxl_w);
    fzl_w = azim_out_w.flip ? UW'(-vzl_w) : UW'(vzl_w);
    fxh_w = azim_out_w.flip ? UW'(-vxh_w) : UW'(vxh_w);
    fzh_w = azim_out_w.flip ? UW'(-vzh_w) : UW'(vzh_w);
    res_d = '0;
    if (azim_out_w.degen) begin
      res_d.degenerate     = 1'b1;
      res_d.solution_count = bas_pkg::SOL_NONE;
    end else if (azim_out_w.neg) begin
      res_d.solution_count = bas_pkg::SOL_NONE;
    end else begin
      res_d.low_vx = $signed(bas_pkg::round_out(fxl_w));
      res_d.low_vy = $signed(bas_pkg::round_out(azim_out_w.vy_low));
      res_d.low_vz = $signed(bas_pkg::round_out(fzl_w));
      if (azim_out_w.rootz) begin
        res_d.solution_count = bas_pkg::SOL_ONE;
      end else begin
        res_d.solution_count = bas_pkg::SOL_TWO;
        res_d.high_vx        = $signed(bas_pkg::round_out(fxh_w));
        res_d.high_vy        = $signed(bas_pkg::round_out(azim_out_w.vy_high));
        res_d.high_vz        = $signed(bas_pkg::round_out(fzh_w));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= c2l_valid_w;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // The two root units and the paired CORDIC units stay in step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_valid_w == rd_valid_w)
    else $error("root units out of step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c1l_valid_w == c1h_valid_w) && (c2l_valid_w == c2h_valid_w))
    else $error("arc CORDIC units out of step");

  // A degenerate beat reports no solution, and a beat with under two solutions has no steep fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.degenerate |-> res_o.solution_count == bas_pkg::SOL_NONE)
    else $error("degenerate beat with solutions");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.solution_count != bas_pkg::SOL_TWO |->
      res_o.high_vx == '0 && res_o.high_vy == '0 && res_o.high_vz == '0)
    else $error("steep arc fields set without two solutions");

endmodule
